// ----- rtl/jhs_pkg.sv -----
`timescale 1ns / 1ps

package jhs_pkg;

    // default grid capacity
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // field widths
    localparam int CELL_W  = 24;
    localparam int ITER_W  = 16;
    localparam int EPS_W   = 56;
    localparam int SUM_W   = 60;
    localparam int SIZE_W  = 7;
    localparam int IDX_W   = 6;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 56;

    // input kind codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_GRID_ROWS  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_GRID_COLS  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ITER_LIMIT = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_EPS_SQ     = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_LEFT       = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_RIGHT      = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_TOP        = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_BOTTOM     = 3'd7;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_GRID_ROWS  = 7'd12;
    localparam logic [SIZE_W-1:0] RST_GRID_COLS  = 7'd12;
    localparam logic [ITER_W-1:0] RST_ITER_LIMIT = 16'd1000;
    localparam logic [EPS_W-1:0]  RST_EPS_SQ     = 56'd281;
    localparam logic [CELL_W-1:0] RST_LEFT       = 24'd838861;
    localparam logic [CELL_W-1:0] RST_RIGHT      = 24'd1677722;
    localparam logic [CELL_W-1:0] RST_TOP        = 24'd335544;
    localparam logic [CELL_W-1:0] RST_BOTTOM     = 24'd3355443;

    typedef struct packed {
        logic [SIZE_W-1:0] grid_rows;
        logic [SIZE_W-1:0] grid_cols;
        logic [ITER_W-1:0] iteration_limit;
        logic [EPS_W-1:0]  epsilon_squared;
        logic [CELL_W-1:0] left_edge_value;
        logic [CELL_W-1:0] right_edge_value;
        logic [CELL_W-1:0] top_edge_value;
        logic [CELL_W-1:0] bottom_edge_value;
    } t_cfg;

    typedef struct packed {
        logic              converged;
        logic [ITER_W-1:0] iterations_done;
        logic [CELL_W-1:0] cell_value;
    } t_result;

endpackage

// ----- rtl/jhs_bank.sv -----
`timescale 1ns / 1ps

module jhs_bank #(
    parameter int DEPTH = jhs_pkg::DEF_MAX_ROWS * jhs_pkg::DEF_MAX_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [jhs_pkg::CELL_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [jhs_pkg::CELL_W-1:0]  o_rdata
);

    logic [jhs_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [jhs_pkg::CELL_W-1:0] r_rdata;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/jhs_core.sv -----
`timescale 1ns / 1ps

module jhs_core #(
    parameter int MAX_ROWS = jhs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = jhs_pkg::DEF_MAX_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jhs_pkg::t_cfg                 i_cfg,
    input  logic                          i_start,
    input  logic                          i_op,
    input  logic [jhs_pkg::IDX_W-1:0]     i_row,
    input  logic [jhs_pkg::IDX_W-1:0]     i_col,
    output logic                          o_idle,
    output logic                          o_res_valid,
    output jhs_pkg::t_result              o_res
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int CELLW = jhs_pkg::CELL_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CALC  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_ENDS  = 4'd6;
    localparam logic [3:0] S_RWAIT = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                  r_state;
    logic [RW-1:0]               r_rows, r_row;
    logic [CW-1:0]               r_cols, r_col;
    logic [2:0]                  r_step;
    logic                        r_bank;
    logic [CELLW+1:0]            r_sum;
    logic [CELLW-1:0]            r_old;
    logic [CELLW-1:0]            r_diff;
    logic [2*CELLW-1:0]          r_sq;
    logic [jhs_pkg::SUM_W-1:0]   r_chg;
    logic [jhs_pkg::ITER_W-1:0]  r_sweep;
    logic                        r_conv;
    logic                        r_rd_ok;
    logic                        r_is_read;

    logic [RW-1:0]               n_rows;
    logic [CW-1:0]               n_cols;
    logic [AW-1:0]               w_p;
    logic [AW-1:0]               w_raddr;
    logic [AW-1:0]               w_rd_addr;
    logic [AW-1:0]               w_waddr;
    logic [CELLW-1:0]            w_wdata;
    logic                        w_init_we;
    logic                        w_calc_we;
    logic [CELLW-1:0]            w_rdata0, w_rdata1, w_cur;
    logic [CELLW-1:0]            w_nv;
    logic [CELLW-1:0]            w_init_val;
    logic [jhs_pkg::SUM_W:0]     w_acc;
    logic [jhs_pkg::ITER_W-1:0]  w_sweep_inc;
    logic                        w_more;
    logic                        w_rd_in;

    // grid size clamped to the supported range
    always_comb begin
        if (int'(i_cfg.grid_rows) < 3) begin
            n_rows = RW'(3);
        end else if (int'(i_cfg.grid_rows) > MAX_ROWS) begin
            n_rows = RW'(MAX_ROWS);
        end else begin
            n_rows = RW'(i_cfg.grid_rows);
        end
        if (int'(i_cfg.grid_cols) < 3) begin
            n_cols = CW'(3);
        end else if (int'(i_cfg.grid_cols) > MAX_COLS) begin
            n_cols = CW'(MAX_COLS);
        end else begin
            n_cols = CW'(i_cfg.grid_cols);
        end
    end

    // linear address of the current cell
    assign w_p = AW'(int'(r_row) * MAX_COLS + int'(r_col));
    assign w_rd_addr = AW'(int'(i_row) * MAX_COLS + int'(i_col));
    assign w_rd_in = (int'(i_row) < int'(r_rows)) && (int'(i_col) < int'(r_cols));

    // neighbor read sequence: east, west, south, north, center
    always_comb begin
        w_raddr = w_p;
        if (r_state == S_IDLE) begin
            w_raddr = w_rd_addr;
        end else begin
            case (r_step)
                3'd0:    w_raddr = AW'(int'(w_p) + 1);
                3'd1:    w_raddr = AW'(int'(w_p) - 1);
                3'd2:    w_raddr = AW'(int'(w_p) + MAX_COLS);
                3'd3:    w_raddr = AW'(int'(w_p) - MAX_COLS);
                default: w_raddr = w_p;
            endcase
        end
    end

    // fixed edge values, top and bottom win at corners
    always_comb begin
        if (r_row == '0) begin
            w_init_val = i_cfg.top_edge_value;
        end else if (int'(r_row) == int'(r_rows) - 1) begin
            w_init_val = i_cfg.bottom_edge_value;
        end else if (r_col == '0) begin
            w_init_val = i_cfg.left_edge_value;
        end else if (int'(r_col) == int'(r_cols) - 1) begin
            w_init_val = i_cfg.right_edge_value;
        end else begin
            w_init_val = '0;
        end
    end

    assign w_nv      = r_sum[CELLW+1:2];
    assign w_init_we = (r_state == S_INIT);
    assign w_calc_we = (r_state == S_CALC);
    assign w_waddr   = w_p;
    assign w_wdata   = w_init_we ? w_init_val : w_nv;

    jhs_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_init_we | (w_calc_we & r_bank)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata0)
    );

    jhs_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_init_we | (w_calc_we & ~r_bank)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata1)
    );

    assign w_cur = r_bank ? w_rdata1 : w_rdata0;

    // saturating change accumulator and loop test
    assign w_acc       = {1'b0, r_chg} + (jhs_pkg::SUM_W + 1)'(r_sq);
    assign w_sweep_inc = r_sweep + 1'b1;
    assign w_more      = (r_chg >= jhs_pkg::SUM_W'(i_cfg.epsilon_squared))
                      && (w_sweep_inc < i_cfg.iteration_limit);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rows    <= '0;
            r_cols    <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_step    <= '0;
            r_bank    <= 1'b0;
            r_chg     <= '0;
            r_sweep   <= '0;
            r_conv    <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_is_read <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_op == jhs_pkg::OP_READ) begin
                            r_is_read <= 1'b1;
                            r_rd_ok   <= w_rd_in;
                            r_state   <= S_RWAIT;
                        end else begin
                            r_is_read <= 1'b0;
                            r_rows    <= n_rows;
                            r_cols    <= n_cols;
                            r_row     <= '0;
                            r_col     <= '0;
                            r_bank    <= 1'b0;
                            r_chg     <= '0;
                            r_sweep   <= '0;
                            r_state   <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (int'(r_col) == int'(r_cols) - 1) begin
                        r_col <= '0;
                        if (int'(r_row) == int'(r_rows) - 1) begin
                            r_row   <= RW'(1);
                            r_col   <= CW'(1);
                            r_step  <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_RD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd5) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_chg  <= w_acc[jhs_pkg::SUM_W] ? '1 : w_acc[jhs_pkg::SUM_W-1:0];
                    r_step <= '0;
                    if (int'(r_col) + 1 < int'(r_cols) - 1) begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_col <= CW'(1);
                        if (int'(r_row) + 1 < int'(r_rows) - 1) begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_row   <= RW'(1);
                            r_state <= S_ENDS;
                        end
                    end
                end
                S_ENDS: begin
                    r_sweep <= w_sweep_inc;
                    r_bank  <= ~r_bank;
                    if (w_more) begin
                        r_chg   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_conv  <= (r_chg < jhs_pkg::SUM_W'(i_cfg.epsilon_squared));
                        r_state <= S_DONE;
                    end
                end
                S_RWAIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // stencil datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            if (r_step == 3'd0) begin
                r_sum <= '0;
            end else if (r_step == 3'd5) begin
                r_old <= w_cur;
            end else begin
                r_sum <= r_sum + (CELLW + 2)'(w_cur);
            end
        end
        if (r_state == S_CALC) begin
            r_diff <= (w_nv >= r_old) ? (w_nv - r_old) : (r_old - w_nv);
        end
        if (r_state == S_SQ) begin
            r_sq <= r_diff * r_diff;
        end
    end

    // result capture for a read
    logic [CELLW-1:0] r_cell;
    always_ff @(posedge i_clk) begin
        if (r_state == S_RWAIT) begin
            r_cell <= r_rd_ok ? w_cur : '0;
        end
    end

    assign o_idle                    = (r_state == S_IDLE);
    assign o_res_valid               = (r_state == S_DONE);
    assign o_res.cell_value          = r_is_read ? r_cell : '0;
    assign o_res.iterations_done     = r_sweep;
    assign o_res.converged           = r_conv;

endmodule

// ----- rtl/jacobi_heat_stencil_solver_top.sv -----
`timescale 1ns / 1ps

// Jacobi heat solver, five-point stencil on a grid of up to MAX_ROWS x MAX_COLS.
// Input stream: tuser carries op (start a run or read a cell), tdata carries
// row_index and col_index. Every input transfer gives exactly one output transfer
// with cell_value, iterations_done and converged.
// A start run first lays down the edges and zeroes the interior, then for
// each interior cell on each sweep makes five reads through the read port of
// the source bank, then computes, squares and accumulates, with a loop test
// at the end of each sweep.
// A read fetches the cell from the grid memory, captures it in S_RWAIT and
// presents it in S_DONE.
// Two grid banks alternate between source and destination on every sweep.
// One item is in work at a time; a new item is taken once the output register
// is empty or is being drained in the same cycle. A stalled receiver holds
// the result in the output register and the input side waits.
// Reset (synchronous, active low) returns the registers to their defaults and
// clears counters and flags; grid contents are undefined until a run starts.
// Configuration writes are taken any cycle and must only happen while idle.

module jacobi_heat_stencil_solver_top #(
    parameter int MAX_ROWS = jhs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = jhs_pkg::DEF_MAX_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [jhs_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [jhs_pkg::CFG_D_W-1:0]   i_cfg_data,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [15:0]                   i_s_axis_tdata,  // row_index[5:0], col_index[11:6]
    input  logic                          i_s_axis_tuser,  // op[0]
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [47:0]                   o_m_axis_tdata   // cell_value[23:0],
                                                           // iterations_done[39:24],
                                                           // converged[40]
);

    jhs_pkg::t_cfg    r_cfg;
    jhs_pkg::t_result w_res;
    jhs_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_idle;
    logic             w_res_valid;
    logic             w_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows         <= jhs_pkg::RST_GRID_ROWS;
            r_cfg.grid_cols         <= jhs_pkg::RST_GRID_COLS;
            r_cfg.iteration_limit   <= jhs_pkg::RST_ITER_LIMIT;
            r_cfg.epsilon_squared   <= jhs_pkg::RST_EPS_SQ;
            r_cfg.left_edge_value   <= jhs_pkg::RST_LEFT;
            r_cfg.right_edge_value  <= jhs_pkg::RST_RIGHT;
            r_cfg.top_edge_value    <= jhs_pkg::RST_TOP;
            r_cfg.bottom_edge_value <= jhs_pkg::RST_BOTTOM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                jhs_pkg::REG_GRID_ROWS:  r_cfg.grid_rows <= i_cfg_data[jhs_pkg::SIZE_W-1:0];
                jhs_pkg::REG_GRID_COLS:  r_cfg.grid_cols <= i_cfg_data[jhs_pkg::SIZE_W-1:0];
                jhs_pkg::REG_ITER_LIMIT: begin
                    r_cfg.iteration_limit <= i_cfg_data[jhs_pkg::ITER_W-1:0];
                end
                jhs_pkg::REG_EPS_SQ:     begin
                    r_cfg.epsilon_squared <= i_cfg_data[jhs_pkg::EPS_W-1:0];
                end
                jhs_pkg::REG_LEFT:       begin
                    r_cfg.left_edge_value <= i_cfg_data[jhs_pkg::CELL_W-1:0];
                end
                jhs_pkg::REG_RIGHT:      begin
                    r_cfg.right_edge_value <= i_cfg_data[jhs_pkg::CELL_W-1:0];
                end
                jhs_pkg::REG_TOP:        begin
                    r_cfg.top_edge_value <= i_cfg_data[jhs_pkg::CELL_W-1:0];
                end
                default:                 begin
                    r_cfg.bottom_edge_value <= i_cfg_data[jhs_pkg::CELL_W-1:0];
                end
            endcase
        end
    end

    // input transfer when the engine is free and the output slot can take a result
    assign o_s_axis_tready = w_idle && (!r_out_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    jhs_core #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (w_accept),
        .i_op        (i_s_axis_tuser),
        .i_row       (i_s_axis_tdata[5:0]),
        .i_col       (i_s_axis_tdata[11:6]),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.converged, r_out.iterations_done, r_out.cell_value};

endmodule
